// ===== design/dps_pkg.sv =====
// ============================================================================
// Debounced power supervisor package
// Shared types, codes and constants for the power supervisor block.
// ============================================================================
package dps_pkg;

    // Width of a converted supply sample.
    localparam int SAMPLE_BITS = 12;

    // Width of the stable count, which saturates one above a 4-bit limit.
    localparam int COUNT_BITS = 5;

    // Width of the configuration register index.
    localparam int CFG_INDEX_BITS = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SETTLE_TICKS   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VDD_THRESHOLD  = 2'd2;

    // Configuration reset values.
    localparam logic [3:0]             DEBOUNCE_LIMIT_RESET = 4'd5;
    localparam logic [3:0]             SETTLE_TICKS_RESET   = 4'd5;
    localparam logic [SAMPLE_BITS-1:0] VDD_THRESHOLD_RESET  = SAMPLE_BITS'(200);

    // Event kinds.
    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Power state codes as reported in a result.
    localparam logic [1:0] PWR_OFF   = 2'd0;
    localparam logic [1:0] PWR_ON    = 2'd1;
    localparam logic [1:0] PWR_ERROR = 2'd2;

    // Internal power mode, one-hot.
    typedef enum logic [2:0] {
        MODE_OFF   = 3'b001,
        MODE_ON    = 3'b010,
        MODE_ERROR = 3'b100
    } dps_mode_t;

    // Input request.
    typedef struct packed {
        logic                   operation;
        logic                   button_level;
        logic [SAMPLE_BITS-1:0] vdd_sample;
    } dps_in_t;

    // Result.
    typedef struct packed {
        logic [1:0] power_state;
        logic       supply_enable;
        logic       clock_enable;
        logic       discharge_active;
        logic       vdd_led;
    } dps_out_t;

    // Configuration register contents.
    typedef struct packed {
        logic [3:0]             debounce_limit;
        logic [3:0]             settle_ticks;
        logic [SAMPLE_BITS-1:0] vdd_threshold;
    } dps_cfg_t;

endpackage

// ===== design/debounced_power_supervisor.sv =====
// ============================================================================
// Debounced power supervisor
// Button debounce, power toggle and supply fault detection.
// ============================================================================
// Usage:
// The input channel (in_valid, in_stall, in_data) carries events: a poll
// tick with a raw button level, or a supply voltage sample. Every event
// yields exactly one result on the output channel (out_valid, out_stall,
// out_data) with the power state, switch drives and LED after the event.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes the debounce limit, settling length and supply threshold; it is
// always ready and should only be used while no event is in flight.
// From request to result an event passes one input register, then the
// state update and one result register. One event is taken per clock
// cycle while the receiver does not stall; the state update lies between the two registers.
// When the receiver stalls, the result register holds; the input register
// then fills and in_stall follows, so nothing is lost or repeated.
// Reset clears both pipeline stages, powers off, clears the debounce and
// restores the register defaults (limit 5, settle 5, threshold 200).
// ============================================================================
module debounced_power_supervisor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  dps_pkg::dps_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output dps_pkg::dps_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dps_pkg::SAMPLE_BITS-1:0]     cfg_data
);
    import dps_pkg::*;

    dps_cfg_t cfg;
    dps_out_t result;

    logic     in_valid_reg;
    dps_in_t  in_data_reg;
    logic     out_valid_reg;
    dps_out_t out_data_reg;

    logic     out_free;
    logic     step;

    // Stage movement.
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    dps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/dps_cfg_regs.sv =====
// ============================================================================
// Power supervisor configuration registers
// Holds the debounce limit, settling length and supply threshold.
// ============================================================================
module dps_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dps_pkg::SAMPLE_BITS-1:0]      cfg_data,
    output dps_pkg::dps_cfg_t                    cfg
);
    import dps_pkg::*;

    dps_cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register write; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_limit <= DEBOUNCE_LIMIT_RESET;
            cfg_reg.settle_ticks   <= SETTLE_TICKS_RESET;
            cfg_reg.vdd_threshold  <= VDD_THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_LIMIT: cfg_reg.debounce_limit <= cfg_data[3:0];
                CFG_SETTLE_TICKS:   cfg_reg.settle_ticks   <= cfg_data[3:0];
                CFG_VDD_THRESHOLD:  cfg_reg.vdd_threshold  <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/dps_core.sv =====
// ============================================================================
// Power supervisor core
// Debounce and power state logic; updates its state once per event.
// ============================================================================
module dps_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  dps_pkg::dps_in_t   item,
    input  dps_pkg::dps_cfg_t  cfg,
    output dps_pkg::dps_out_t  result
);
    import dps_pkg::*;

    logic                  last_button_reg, last_button_next;
    logic [COUNT_BITS-1:0] stable_count_reg, stable_count_next;
    dps_mode_t             mode_reg, mode_next;
    logic [3:0]            settle_count_reg, settle_count_next;
    logic                  supply_on_reg, supply_on_next;
    logic                  clock_on_reg, clock_on_next;
    logic                  discharging_reg, discharging_next;
    logic                  led_on_reg, led_on_next;

    logic [COUNT_BITS-1:0] limit_ext;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  present;

    assign limit_ext = {1'b0, cfg.debounce_limit};
    assign count_inc = (stable_count_reg < limit_ext + 1'b1)
                     ? stable_count_reg + 1'b1 : stable_count_reg;
    assign present   = item.vdd_sample > cfg.vdd_threshold;

    // Next state for the event at hand.
    always_comb
    begin
        last_button_next  = last_button_reg;
        stable_count_next = stable_count_reg;
        mode_next         = mode_reg;
        settle_count_next = settle_count_reg;
        supply_on_next    = supply_on_reg;
        clock_on_next     = clock_on_reg;
        discharging_next  = discharging_reg;
        led_on_next       = led_on_reg;

        if (item.operation == OP_POLL)
        begin
            if (item.button_level != last_button_reg)
            begin
                // A change of level restarts the debounce.
                stable_count_next = '0;
                last_button_next  = item.button_level;
            end
            else
            begin
                stable_count_next = count_inc;
                if (count_inc == limit_ext && item.button_level)
                begin
                    // Confirmed press toggles power.
                    settle_count_next = cfg.settle_ticks;
                    if (mode_reg == MODE_ON)
                    begin
                        mode_next        = MODE_OFF;
                        clock_on_next    = 1'b0;
                        supply_on_next   = 1'b0;
                        discharging_next = 1'b1;
                    end
                    else
                    begin
                        mode_next        = MODE_ON;
                        discharging_next = 1'b0;
                        supply_on_next   = 1'b1;
                        clock_on_next    = 1'b1;
                    end
                end
            end
        end
        else
        begin
            // Supply sample: fault check, LED and settling countdown.
            if (mode_reg == MODE_ON && settle_count_reg == 4'd0 && !present)
            begin
                mode_next      = MODE_ERROR;
                supply_on_next = 1'b0;
            end
            led_on_next = present;
            if (settle_count_reg != 4'd0)
            begin
                settle_count_next = settle_count_reg - 1'b1;
            end
        end
    end

    // State registers advance when an event completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_button_reg  <= 1'b0;
            stable_count_reg <= '0;
            mode_reg         <= MODE_OFF;
            settle_count_reg <= 4'd0;
            supply_on_reg    <= 1'b0;
            clock_on_reg     <= 1'b0;
            discharging_reg  <= 1'b0;
            led_on_reg       <= 1'b0;
        end
        else if (step)
        begin
            last_button_reg  <= last_button_next;
            stable_count_reg <= stable_count_next;
            mode_reg         <= mode_next;
            settle_count_reg <= settle_count_next;
            supply_on_reg    <= supply_on_next;
            clock_on_reg     <= clock_on_next;
            discharging_reg  <= discharging_next;
            led_on_reg       <= led_on_next;
        end
    end

    // Result shows the state after the event.
    always_comb
    begin
        case (mode_next)
            MODE_OFF:   result.power_state = PWR_OFF;
            MODE_ON:    result.power_state = PWR_ON;
            MODE_ERROR: result.power_state = PWR_ERROR;
            default:    result.power_state = PWR_OFF;
        endcase
        result.supply_enable    = supply_on_next;
        result.clock_enable     = clock_on_next;
        result.discharge_active = discharging_next;
        result.vdd_led          = led_on_next;
    end

endmodule

// ===== tb/debounced_power_supervisor_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Debounced power supervisor testbench
// Drives poll ticks and supply samples into the supervisor and scores every
// result against a cycle-free model of the debounce, toggle and fault logic.
// A directed table runs first. Randomized press, release, bounce and sample
// sequences follow under several register settings, with random stalls on
// both channels.
// ============================================================================
module debounced_power_supervisor_test;
    import dps_pkg::*;

    localparam int HOLD_CYCLES = 60;

    // One row of the directed table. When checked is set, the expected
    // result is the typed one; otherwise the model supplies it.
    typedef struct {
        logic                   op;
        logic                   btn;
        logic [SAMPLE_BITS-1:0] vdd;
        bit                     checked;
        logic [1:0]             state;
        logic                   supply;
        logic                   clock_en;
        logic                   discharge;
        logic                   led;
    } script_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    dps_in_t                     in_data = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    dps_out_t                    out_data;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [SAMPLE_BITS-1:0]      cfg_data = '0;

    // Model of the register file.
    logic [3:0]             limit_reg  = DEBOUNCE_LIMIT_RESET;
    logic [3:0]             settle_reg = SETTLE_TICKS_RESET;
    logic [SAMPLE_BITS-1:0] thr_reg    = VDD_THRESHOLD_RESET;

    // Model of the supervisor state after reset.
    logic                  btn_last      = 1'b0;
    logic [COUNT_BITS-1:0] btn_stable    = '0;
    logic [1:0]            pwr_mode      = PWR_OFF;
    logic [3:0]            settle_left   = 4'd0;
    logic                  supply_drv    = 1'b0;
    logic                  clock_drv     = 1'b0;
    logic                  discharge_drv = 1'b0;
    logic                  led_drv       = 1'b0;

    dps_out_t pending_status [$];
    int       fail_count  = 0;
    int       idle_odds   = 0;
    bit       hold_output = 1'b0;

    // Directed table, run with the reset register values.
    script_row_t script [] = '{
        '{OP_SAMPLE, 1'b1, 12'd0,    1'b1, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_SAMPLE, 1'b0, 12'd4095, 1'b1, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b1},
        '{OP_POLL,   1'b1, 12'd4095, 1'b1, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b1},
        '{OP_POLL,   1'b1, 12'd0,    1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'hAAA,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'h555,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'd0,    1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'hFFF,  1'b1, PWR_ON,    1'b1, 1'b1, 1'b0, 1'b1},
        '{OP_POLL,   1'b1, 12'd7,    1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'd9,    1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_SAMPLE, 1'b1, 12'd200,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_SAMPLE, 1'b0, 12'd200,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_SAMPLE, 1'b1, 12'd200,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_SAMPLE, 1'b0, 12'd200,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_SAMPLE, 1'b1, 12'd200,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_SAMPLE, 1'b0, 12'd201,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_SAMPLE, 1'b1, 12'd0,    1'b1, PWR_ERROR, 1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_POLL,   1'b0, 12'hFFF,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'd0,    1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'h800,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'h001,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'h7FF,  1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'd3,    1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POLL,   1'b1, 12'd0,    1'b1, PWR_ON,    1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_SAMPLE, 1'b0, 12'd0,    1'b0, PWR_OFF,   1'b0, 1'b0, 1'b0, 1'b0}
    };

    debounced_power_supervisor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the supervisor model by one event and return its status.
    function automatic dps_out_t supervise_event(input dps_in_t ev);
        logic     present;
        dps_out_t status;
        if (ev.operation == OP_POLL)
        begin
            if (ev.button_level != btn_last)
            begin
                // A level change restarts the debounce and does nothing else.
                btn_stable = '0;
                btn_last   = ev.button_level;
            end
            else
            begin
                if (btn_stable < {1'b0, limit_reg} + 5'd1)
                    btn_stable = btn_stable + 5'd1;
                if (btn_stable == {1'b0, limit_reg} && ev.button_level)
                begin
                    settle_left = settle_reg;
                    if (pwr_mode == PWR_ON)
                    begin
                        pwr_mode      = PWR_OFF;
                        clock_drv     = 1'b0;
                        supply_drv    = 1'b0;
                        discharge_drv = 1'b1;
                    end
                    else
                    begin
                        pwr_mode      = PWR_ON;
                        discharge_drv = 1'b0;
                        supply_drv    = 1'b1;
                        clock_drv     = 1'b1;
                    end
                end
            end
        end
        else
        begin
            present = (ev.vdd_sample > thr_reg);
            // Missing supply after settling is a fault; clock and discharge hold.
            if (pwr_mode == PWR_ON && settle_left == 4'd0 && !present)
            begin
                pwr_mode   = PWR_ERROR;
                supply_drv = 1'b0;
            end
            led_drv = present;
            if (settle_left != 4'd0)
                settle_left = settle_left - 4'd1;
        end
        status.power_state      = pwr_mode;
        status.supply_enable    = supply_drv;
        status.clock_enable     = clock_drv;
        status.discharge_active = discharge_drv;
        status.vdd_led          = led_drv;
        return status;
    endfunction

    // Offer one request, wait for it to be taken, then idle at random.
    task automatic offer_event(input dps_in_t ev, input bit use_typed,
                               input dps_out_t typed);
        dps_out_t status;
        in_data  <= ev;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        status = supervise_event(ev);
        pending_status.push_back(use_typed ? typed : status);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
    endtask

    task automatic send_item(input dps_in_t ev);
        offer_event(ev, 1'b0, '0);
    endtask

    // Poll tick; the sample field is ignored and carries noise.
    function automatic dps_in_t poll_event(input logic level);
        dps_in_t ev;
        ev.operation    = OP_POLL;
        ev.button_level = level;
        ev.vdd_sample   = SAMPLE_BITS'($urandom);
        return ev;
    endfunction

    // Supply sample, biased toward the extremes and the threshold edge.
    function automatic dps_in_t supply_event();
        dps_in_t ev;
        ev.operation    = OP_SAMPLE;
        ev.button_level = 1'($urandom);
        case ($urandom_range(0, 7))
            0: ev.vdd_sample = '0;
            1: ev.vdd_sample = '1;
            2: ev.vdd_sample = thr_reg;
            3: ev.vdd_sample = thr_reg + 1'b1;
            4: ev.vdd_sample = thr_reg - 1'b1;
            5, 6:
            begin
                if (thr_reg != '1)
                    ev.vdd_sample = SAMPLE_BITS'($urandom_range(thr_reg + 1, 4095));
                else
                    ev.vdd_sample = SAMPLE_BITS'($urandom);
            end
            default: ev.vdd_sample = SAMPLE_BITS'($urandom);
        endcase
        return ev;
    endfunction

    // Write all three registers back to back; only called with nothing in flight.
    task automatic apply_settings(input logic [3:0] lim, input logic [3:0] settle,
                                  input logic [SAMPLE_BITS-1:0] thr);
        logic [CFG_INDEX_BITS-1:0] idx [3];
        logic [SAMPLE_BITS-1:0]    val [3];
        idx[0] = CFG_DEBOUNCE_LIMIT;
        idx[1] = CFG_SETTLE_TICKS;
        idx[2] = CFG_VDD_THRESHOLD;
        val[0] = SAMPLE_BITS'(lim);
        val[1] = SAMPLE_BITS'(settle);
        val[2] = thr;
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                CFG_DEBOUNCE_LIMIT: limit_reg  = val[i][3:0];
                CFG_SETTLE_TICKS:   settle_reg = val[i][3:0];
                CFG_VDD_THRESHOLD:  thr_reg    = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Random button and supply activity, mostly well-formed presses.
    task automatic run_traffic(input int count);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 8)
            begin
                // Press: optional release, then a hold that is usually long enough to confirm.
                if ($urandom_range(0, 1) == 1)
                begin
                    send_item(poll_event(1'b0));
                    sent++;
                end
                len = limit_reg + $urandom_range(0, 3);
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, limit_reg + 1);
                repeat (len)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_item(supply_event());
                        sent++;
                    end
                    send_item(poll_event(1'b1));
                    sent++;
                end
            end
            else if (kind < 13)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(poll_event(1'b0));
                    sent++;
                end
            end
            else if (kind < 15)
            begin
                // Contact bounce.
                repeat ($urandom_range(1, 6))
                begin
                    send_item(poll_event(1'($urandom)));
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    send_item(supply_event());
                    sent++;
                end
            end
        end
    endtask

    // Receiver pacing: random stall bursts, or one long hold on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                out_stall <= 1'b0;
                hold_output = 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18))
                    @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Score each accepted result against the oldest expectation.
    always @(posedge clk)
    begin : score_results
        dps_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $error("unexpected result %h with no request outstanding", out_data);
                fail_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                if (out_data.power_state !== want.power_state)
                begin
                    $error("power_state: expected %0d, got %0d",
                           want.power_state, out_data.power_state);
                    fail_count++;
                end
                if (out_data.supply_enable !== want.supply_enable)
                begin
                    $error("supply_enable: expected %0d, got %0d",
                           want.supply_enable, out_data.supply_enable);
                    fail_count++;
                end
                if (out_data.clock_enable !== want.clock_enable)
                begin
                    $error("clock_enable: expected %0d, got %0d",
                           want.clock_enable, out_data.clock_enable);
                    fail_count++;
                end
                if (out_data.discharge_active !== want.discharge_active)
                begin
                    $error("discharge_active: expected %0d, got %0d",
                           want.discharge_active, out_data.discharge_active);
                    fail_count++;
                end
                if (out_data.vdd_led !== want.vdd_led)
                begin
                    $error("vdd_led: expected %0d, got %0d",
                           want.vdd_led, out_data.vdd_led);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        dps_in_t  ev;
        dps_out_t typed;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table with reset settings and light idling.
        idle_odds = 5;
        foreach (script[i])
        begin
            ev.operation            = script[i].op;
            ev.button_level         = script[i].btn;
            ev.vdd_sample           = script[i].vdd;
            typed.power_state       = script[i].state;
            typed.supply_enable     = script[i].supply;
            typed.clock_enable      = script[i].clock_en;
            typed.discharge_active  = script[i].discharge;
            typed.vdd_led           = script[i].led;
            offer_event(ev, script[i].checked, typed);
        end

        // Shortest debounce, no settling, every sample counts as present but zero.
        wait_results_drained();
        apply_settings(4'd1, 4'd0, '0);
        idle_odds = 4;
        run_traffic(90);

        // Longest debounce and settling; no sample can ever count as present.
        wait_results_drained();
        apply_settings(4'd15, 4'd15, '1);
        idle_odds = 3;
        run_traffic(90);

        // Zero debounce limit never confirms a press; run with no idling.
        wait_results_drained();
        apply_settings(4'd0, 4'd7, 12'd2048);
        idle_odds = 0;
        run_traffic(50);

        // Random settings; the receiver holds off while requests keep coming.
        wait_results_drained();
        apply_settings(4'($urandom_range(1, 15)), 4'($urandom), SAMPLE_BITS'($urandom));
        idle_odds = 0;
        hold_output = 1'b1;
        run_traffic(30);
        idle_odds = 8;
        run_traffic(70);

        // Pause until everything is back, then heavy idling on both sides.
        wait_results_drained();
        apply_settings(4'($urandom), 4'($urandom), SAMPLE_BITS'($urandom));
        idle_odds = 2;
        run_traffic(90);

        // Final stretch at full rate.
        wait_results_drained();
        apply_settings(4'd2, 4'd1, 12'd100);
        idle_odds = 0;
        run_traffic(100);

        wait_results_drained();
        repeat (8)
            @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
